[sv/llrm_pkg.sv]
// ----------------------------------------------------------------------------
// llrm_pkg
// types and constants for the looping linear resample mixer
// ----------------------------------------------------------------------------
package llrm_pkg;

    localparam int DEF_MAX_FRAMES    = 65536;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int STEP_W  = 18;
    localparam int GAIN_W  = 9;
    localparam int COUNT_W = 17;
    localparam int POS_W   = 18;

    localparam logic [STEP_W-1:0] STEP_RESET = 18'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd256;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 9'd256;

    localparam logic [1:0] REG_STEP_RATIO  = 2'd0;
    localparam logic [1:0] REG_GAIN        = 2'd1;
    localparam logic [1:0] REG_LOOP_ENABLE = 2'd2;
    localparam logic [1:0] REG_FRAME_COUNT = 2'd3;

    localparam logic [2:0] MODE_WRITE  = 3'd0;
    localparam logic [2:0] MODE_PLAY   = 3'd1;
    localparam logic [2:0] MODE_PAUSE  = 3'd2;
    localparam logic [2:0] MODE_RESUME = 3'd3;
    localparam logic [2:0] MODE_STOP   = 3'd4;
    localparam logic [2:0] MODE_MIX    = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ0,
        ST_READ1,
        ST_MUL_L,
        ST_MUL_R,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_ACC_R,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [15:0]        write_index;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic signed [31:0] acc_left;
        logic signed [31:0] acc_right;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] mixed_left;
        logic signed [31:0] mixed_right;
        logic               is_playing;
    } out_item_t;

endpackage

[sv/looping_linear_resample_mixer.sv]
// ----------------------------------------------------------------------------
// looping_linear_resample_mixer
// stereo track player with linear resampling, gain and accumulator mixing
// ----------------------------------------------------------------------------
// The track is loaded one stereo frame per write item into an on-chip sample
// store of MAX_FRAMES entries; its contents are undefined until written and
// there is no clearing pass. Transport items (play, pause, resume, stop),
// write items, unknown modes and mix items that find no playing track go from
// idle straight to the done step, which loads the output register. A mix item
// that plays a frame passes through these steps in order: two reads through the
// single read port of the sample store, then four multiplies in turn on one
// shared multiplier (17 x 17 bit with 16 fraction bits; two interpolations,
// two gain scalings), a final accumulate and the load of the output register.
// One item is worked on at a time; item_stall is high until the block is back
// in idle, and a waiting result does not block acceptance of the next item.
// ----------------------------------------------------------------------------
module looping_linear_resample_mixer #(
    parameter int MAX_FRAMES    = llrm_pkg::DEF_MAX_FRAMES,
    parameter int FRACTION_BITS = llrm_pkg::DEF_FRACTION_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  llrm_pkg::in_item_t              item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output llrm_pkg::out_item_t             result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [llrm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [llrm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [llrm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int FB = FRACTION_BITS;
    // second operand holds the fraction and a gain of up to 256 as positive values
    localparam int MB = (FB + 1 > 10) ? FB + 1 : 10;
    localparam int PW = MB + 17;
    localparam int TW = FB + 19;
    localparam int SX = FB + llrm_pkg::STEP_W;

    // configuration
    logic [llrm_pkg::STEP_W-1:0]  step_reg;
    logic [llrm_pkg::GAIN_W-1:0]  gain_reg;
    logic                         loop_reg;
    logic [llrm_pkg::COUNT_W-1:0] count_reg;

    // control
    llrm_pkg::state_t             state_reg, state_next;
    logic [llrm_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [FB-1:0]                frac_reg, frac_next;
    logic                         active_reg, active_next;
    logic                         running_reg, running_next;
    logic                         out_valid_reg, out_valid_next;

    // datapath
    logic signed [PW-1:0]         prod_reg, prod_next;
    logic signed [15:0]           lerp_l_reg, lerp_l_next;
    logic signed [15:0]           lerp_r_reg, lerp_r_next;
    logic [31:0]                  mix_l_reg, mix_l_next;
    logic [31:0]                  mix_r_reg, mix_r_next;
    logic [31:0]                  f0_reg, f0_next;
    logic [31:0]                  rdata_reg;
    llrm_pkg::out_item_t          result_reg, result_next;

    logic [31:0]                  store_mem [MAX_FRAMES];

    logic                         cfg_write;
    logic                         accept;
    logic                         mix_go;
    logic                         at_end;
    logic                         mem_we;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [llrm_pkg::COUNT_W-1:0] cnt;
    logic [llrm_pkg::GAIN_W-1:0]  gain_sat;
    logic [llrm_pkg::POS_W-1:0]   pos_inc;
    logic [llrm_pkg::POS_W-1:0]   idx1;
    logic [SX-1:0]                step_ext;
    logic [FB:0]                  frac_sum;
    logic                         out_load;
    logic signed [16:0]           mul_a;
    logic signed [MB-1:0]         mul_b;
    logic signed [PW-1:0]         mul_p;

    function automatic logic signed [15:0] lerp_fix(
        input logic signed [15:0]   a,
        input logic signed [PW-1:0] p
    );
        logic signed [TW-1:0]    t;
        logic signed [TW-FB-1:0] q;
        t = {{3{a[15]}}, a, {FB{1'b0}}} + TW'(p);
        q = t[TW-1:FB];
        // round toward zero for negative values with a remainder
        if (t[TW-1] && (t[FB-1:0] != '0))
        begin
            q = q + (TW-FB)'(1);
        end
        return q[15:0];
    endfunction

    function automatic logic [31:0] gain_term(input logic signed [PW-1:0] p);
        return {{15{p[24]}}, p[24:8]};
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            llrm_pkg::REG_STEP_RATIO:  prdata = 32'(step_reg);
            llrm_pkg::REG_GAIN:        prdata = 32'(gain_reg);
            llrm_pkg::REG_LOOP_ENABLE: prdata = 32'(loop_reg);
            llrm_pkg::REG_FRAME_COUNT: prdata = 32'(count_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= llrm_pkg::STEP_RESET;
            gain_reg  <= llrm_pkg::GAIN_RESET;
            loop_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                llrm_pkg::REG_STEP_RATIO:  step_reg  <= pwdata[llrm_pkg::STEP_W-1:0];
                llrm_pkg::REG_GAIN:        gain_reg  <= pwdata[llrm_pkg::GAIN_W-1:0];
                llrm_pkg::REG_LOOP_ENABLE: loop_reg  <= pwdata[0];
                llrm_pkg::REG_FRAME_COUNT: count_reg <= pwdata[llrm_pkg::COUNT_W-1:0];
                default:                   loop_reg  <= loop_reg;
            endcase
        end
    end

    // derived values
    assign cnt      = (32'(count_reg) > MAX_FRAMES) ? llrm_pkg::COUNT_W'(MAX_FRAMES)
                                                     : count_reg;
    assign gain_sat = (gain_reg > llrm_pkg::UNITY_GAIN) ? llrm_pkg::UNITY_GAIN : gain_reg;
    assign at_end   = (pos_reg >= {1'b0, cnt});
    assign mix_go   = active_reg && running_reg && (cnt != '0) && (!at_end || loop_reg);
    assign pos_inc  = pos_reg + llrm_pkg::POS_W'(1);
    assign idx1     = (pos_inc >= {1'b0, cnt}) ? (loop_reg ? '0 : pos_reg) : pos_inc;
    assign step_ext = SX'(step_reg);
    assign frac_sum = {1'b0, frac_reg} + {1'b0, step_ext[FB-1:0]};
    assign accept   = item_valid && !item_stall;
    assign mem_we   = accept && (item.mode == llrm_pkg::MODE_WRITE)
                      && (32'(item.write_index) < MAX_FRAMES);
    assign mul_p    = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            llrm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if ((item.mode == llrm_pkg::MODE_MIX) && mix_go)
                    begin
                        state_next = llrm_pkg::ST_READ0;
                    end
                    else
                    begin
                        state_next = llrm_pkg::ST_DONE;
                    end
                end
            end
            llrm_pkg::ST_READ0:  state_next = llrm_pkg::ST_READ1;
            llrm_pkg::ST_READ1:  state_next = llrm_pkg::ST_MUL_L;
            llrm_pkg::ST_MUL_L:  state_next = llrm_pkg::ST_MUL_R;
            llrm_pkg::ST_MUL_R:  state_next = llrm_pkg::ST_GAIN_L;
            llrm_pkg::ST_GAIN_L: state_next = llrm_pkg::ST_GAIN_R;
            llrm_pkg::ST_GAIN_R: state_next = llrm_pkg::ST_ACC_R;
            llrm_pkg::ST_ACC_R:  state_next = llrm_pkg::ST_DONE;
            llrm_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = llrm_pkg::ST_IDLE;
                end
            end
            default:             state_next = llrm_pkg::ST_IDLE;
        endcase
    end

    // state decode: handshake, store read and shared multiplier operands
    always_comb
    begin
        item_stall = (state_reg != llrm_pkg::ST_IDLE);
        out_load   = (state_reg == llrm_pkg::ST_DONE) && !(out_valid_reg && result_stall);
        mem_re     = 1'b0;
        mem_raddr  = AW'(pos_reg);
        mul_a      = {f0_reg[15], f0_reg[15:0]};
        mul_b      = MB'(gain_sat);
        case (state_reg)
            llrm_pkg::ST_READ0:
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(pos_reg);
            end
            llrm_pkg::ST_READ1:
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(idx1);
            end
            llrm_pkg::ST_MUL_L:
            begin
                mul_a = {rdata_reg[15], rdata_reg[15:0]} - {f0_reg[15], f0_reg[15:0]};
                mul_b = MB'(frac_reg);
            end
            llrm_pkg::ST_MUL_R:
            begin
                mul_a = {rdata_reg[31], rdata_reg[31:16]} - {f0_reg[31], f0_reg[31:16]};
                mul_b = MB'(frac_reg);
            end
            llrm_pkg::ST_GAIN_L:
            begin
                mul_a = {lerp_l_reg[15], lerp_l_reg};
                mul_b = MB'(gain_sat);
            end
            llrm_pkg::ST_GAIN_R:
            begin
                mul_a = {lerp_r_reg[15], lerp_r_reg};
                mul_b = MB'(gain_sat);
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // datapath and transport state
    always_comb
    begin
        pos_next       = pos_reg;
        frac_next      = frac_reg;
        active_next    = active_reg;
        running_next   = running_reg;
        prod_next      = prod_reg;
        lerp_l_next    = lerp_l_reg;
        lerp_r_next    = lerp_r_reg;
        mix_l_next     = mix_l_reg;
        mix_r_next     = mix_r_reg;
        f0_next        = f0_reg;
        out_valid_next = out_valid_reg && result_stall;
        result_next    = result_reg;
        case (state_reg)
            llrm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mix_l_next = '0;
                    mix_r_next = '0;
                    case (item.mode)
                        llrm_pkg::MODE_PLAY:
                        begin
                            pos_next     = '0;
                            frac_next    = '0;
                            running_next = 1'b1;
                            active_next  = 1'b1;
                        end
                        llrm_pkg::MODE_PAUSE:
                        begin
                            running_next = 1'b0;
                        end
                        llrm_pkg::MODE_RESUME:
                        begin
                            running_next = 1'b1;
                        end
                        llrm_pkg::MODE_STOP:
                        begin
                            running_next = 1'b0;
                            active_next  = 1'b0;
                            pos_next     = '0;
                            frac_next    = '0;
                        end
                        llrm_pkg::MODE_MIX:
                        begin
                            mix_l_next = item.acc_left;
                            mix_r_next = item.acc_right;
                            if (active_reg && running_reg && (cnt != '0) && at_end)
                            begin
                                if (loop_reg)
                                begin
                                    pos_next  = '0;
                                    frac_next = '0;
                                end
                                else
                                begin
                                    running_next = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            mix_l_next = '0;
                        end
                    endcase
                end
            end
            llrm_pkg::ST_READ1:
            begin
                f0_next = rdata_reg;
            end
            llrm_pkg::ST_MUL_L:
            begin
                prod_next = mul_p;
            end
            llrm_pkg::ST_MUL_R:
            begin
                prod_next   = mul_p;
                lerp_l_next = lerp_fix(f0_reg[15:0], prod_reg);
            end
            llrm_pkg::ST_GAIN_L:
            begin
                prod_next   = mul_p;
                lerp_r_next = lerp_fix(f0_reg[31:16], prod_reg);
                pos_next    = pos_reg + step_ext[SX-1:FB] + llrm_pkg::POS_W'(frac_sum[FB]);
                frac_next   = frac_sum[FB-1:0];
            end
            llrm_pkg::ST_GAIN_R:
            begin
                prod_next  = mul_p;
                mix_l_next = mix_l_reg + gain_term(prod_reg);
            end
            llrm_pkg::ST_ACC_R:
            begin
                mix_r_next = mix_r_reg + gain_term(prod_reg);
            end
            llrm_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next         = 1'b1;
                    result_next.mixed_left  = mix_l_reg;
                    result_next.mixed_right = mix_r_reg;
                    result_next.is_playing  = active_reg && running_reg;
                end
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= llrm_pkg::ST_IDLE;
            pos_reg       <= '0;
            frac_reg      <= '0;
            active_reg    <= 1'b0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            frac_reg      <= frac_next;
            active_reg    <= active_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        lerp_l_reg <= lerp_l_next;
        lerp_r_reg <= lerp_r_next;
        mix_l_reg  <= mix_l_next;
        mix_r_reg  <= mix_r_next;
        f0_reg     <= f0_next;
        result_reg <= result_next;
    end

    // sample store: left in low half, right in high half
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[AW'(item.write_index)] <= {item.sample_right, item.sample_left};
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_raddr];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // checks
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.mode == llrm_pkg::MODE_STOP))
        |=> (!active_reg && !running_reg && (pos_reg == '0) && (frac_reg == '0)))
        else $error("stop item did not clear transport state");

    a_read_in_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == llrm_pkg::ST_READ0) |-> (pos_reg < {1'b0, cnt}))
        else $error("store read beyond track end");

    a_mul_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == llrm_pkg::ST_MUL_L) |-> ($past(state_reg) == llrm_pkg::ST_READ1))
        else $error("interpolation started without both frames read");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == llrm_pkg::ST_DONE))
        else $error("result raised outside the done step");

endmodule
